### hdl/mixed_radix_count_histogram_unit_assert.svh
// Assertion macros shared by the histogram unit.
`ifndef MIXED_RADIX_COUNT_HISTOGRAM_UNIT_ASSERT_SVH
`define MIXED_RADIX_COUNT_HISTOGRAM_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MRCH_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mrch: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define MRCH_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mrch: next-cycle check failed");

`endif

### hdl/mrch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrch_pkg;

  localparam int NUM_FIELDS  = 4;
  localparam int VALUE_W     = 4;
  localparam int CARD_W      = 5;
  localparam int IDX_W       = NUM_FIELDS * VALUE_W;
  localparam int DIG_W       = 2;
  localparam int VARS_W      = 3;
  localparam int INDEX_OUT_W = 12;
  localparam int COUNT_OUT_W = 16;
  localparam int CFG_W       = 4;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_VAR_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CARD_A    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARD_B    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CARD_C    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CARD_D    = 3'd4;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INDEX,
    S_UPDATE,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic             done;
    logic             bad;
    logic [IDX_W-1:0] idx;
  } idx_result_t;

endpackage

`default_nettype wire

### hdl/mixed_radix_count_histogram_unit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "mixed_radix_count_histogram_unit_assert.svh"

// Channel   Direction  Handshake                  Word
// sample    in         sample_valid/sample_stall  mode, value_a..value_d, read_index
// result    out        result_valid/result_stall  cell_index, cell_count, bad_value
// config    in         cfg_write                  cfg_index, cfg_data
//
// One item at a time; sample_stall is high while an item is in progress. An add
// runs the multiply-add over the used variables, then reads and writes back the
// counter before its result is loaded; a dropped sample skips the counter. A read
// reads the counter first, a clear sweeps the table, mode 3 only loads a result;
// the next word is taken the cycle after the result is loaded. After reset the
// table is swept to zero before the first word is taken.

module mixed_radix_count_histogram_unit #(
  parameter int MAX_VARS    = 4,
  parameter int MAX_CARD    = 8,
  parameter int TABLE_DEPTH = 4096,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               sample_valid,
  output      logic                               sample_stall,
  input  wire logic [1:0]                         mode,
  input  wire logic [mrch_pkg::VALUE_W-1:0]       value_a,
  input  wire logic [mrch_pkg::VALUE_W-1:0]       value_b,
  input  wire logic [mrch_pkg::VALUE_W-1:0]       value_c,
  input  wire logic [mrch_pkg::VALUE_W-1:0]       value_d,
  input  wire logic [mrch_pkg::INDEX_OUT_W-1:0]   read_index,
  output      logic                               result_valid,
  input  wire logic                               result_stall,
  output      logic [mrch_pkg::INDEX_OUT_W-1:0]   cell_index,
  output      logic [mrch_pkg::COUNT_OUT_W-1:0]   cell_count,
  output      logic                               bad_value,
  input  wire logic                               cfg_write,
  input  wire logic [mrch_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mrch_pkg::CFG_W-1:0]         cfg_data
);
  import mrch_pkg::*;

  localparam int AW      = $clog2(TABLE_DEPTH);
  localparam int VAR_LIM = (MAX_VARS < NUM_FIELDS) ? MAX_VARS : NUM_FIELDS;
  localparam int CW      = (COUNT_BITS > COUNT_OUT_W) ? COUNT_BITS : COUNT_OUT_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

  state_t state;
  state_t state_next;

  logic [VARS_W-1:0]  var_count;
  logic [VALUE_W-1:0] card_a;
  logic [VALUE_W-1:0] card_b;
  logic [VALUE_W-1:0] card_c;
  logic [VALUE_W-1:0] card_d;

  logic [AW-1:0]          clr_addr;
  logic                   clr_item;
  mode_t                  cur_mode;
  logic [AW-1:0]          cur_addr;
  logic [INDEX_OUT_W-1:0] stage_index;
  logic [COUNT_OUT_W-1:0] stage_count;
  logic                   stage_bad;

  logic                                  accept;
  mode_t                                 in_mode;
  logic [VARS_W-1:0]                     vars_eff;
  logic [NUM_FIELDS-1:0][VALUE_W-1:0]    card_raw;
  logic [NUM_FIELDS-1:0][CARD_W-1:0]     card_eff;
  logic [NUM_FIELDS-1:0][VALUE_W-1:0]    values;
  idx_result_t                           idx_res;
  logic                                  idx_fault;
  logic                                  read_ok;
  logic                                  sweep_last;
  logic                                  out_load;
  logic                                  rd_en;
  logic [AW-1:0]                         rd_addr;
  logic [COUNT_BITS-1:0]                 rd_data;
  logic                                  wr_en;
  logic [AW-1:0]                         wr_addr;
  logic [COUNT_BITS-1:0]                 wr_data;
  logic [COUNT_BITS-1:0]                 count_inc;
  logic [CW-1:0]                         count_wide;

  assign in_mode  = mode_t'(mode);
  assign accept   = sample_valid && !sample_stall;
  assign card_raw = {card_d, card_c, card_b, card_a};
  assign values   = {value_d, value_c, value_b, value_a};

  // Out-of-range settings are folded into the legal range here.
  always_comb begin
    for (int i = 0; i < NUM_FIELDS; i++) begin
      if (card_raw[i] == '0) begin
        card_eff[i] = CARD_W'(1);
      end else if ({1'b0, card_raw[i]} > CARD_W'(MAX_CARD)) begin
        card_eff[i] = CARD_W'(MAX_CARD);
      end else begin
        card_eff[i] = {1'b0, card_raw[i]};
      end
    end
    if (var_count == '0) begin
      vars_eff = VARS_W'(1);
    end else if ({1'b0, var_count} > (VARS_W + 1)'(VAR_LIM)) begin
      vars_eff = VARS_W'(VAR_LIM);
    end else begin
      vars_eff = var_count;
    end
  end

  mrch_index_unit u_index (
    .clk    (clk),
    .rst    (rst),
    .start  (accept && in_mode == MODE_ADD),
    .vars   (vars_eff),
    .values (values),
    .cards  (card_eff),
    .res    (idx_res)
  );

  mrch_count_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .W     (COUNT_BITS)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign idx_fault  = idx_res.bad ||
                      ({1'b0, idx_res.idx} >= (IDX_W + 1)'(TABLE_DEPTH));
  assign read_ok    = (IDX_W + 1)'(read_index) < (IDX_W + 1)'(TABLE_DEPTH);
  assign sweep_last = (clr_addr == LAST_ADDR);
  assign count_inc  = (rd_data == '1) ? rd_data : rd_data + COUNT_BITS'(1);
  assign count_wide = CW'((cur_mode == MODE_ADD) ? count_inc : rd_data);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (sweep_last) begin
          state_next = clr_item ? S_HOLD : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_ADD:   state_next = S_INDEX;
            MODE_READ:  state_next = read_ok ? S_UPDATE : S_HOLD;
            MODE_CLEAR: state_next = S_CLEAR;
            MODE_NONE:  state_next = S_HOLD;
          endcase
        end
      end
      S_INDEX: begin
        if (idx_res.done) begin
          state_next = idx_fault ? S_HOLD : S_UPDATE;
        end
      end
      S_UPDATE: state_next = S_HOLD;
      S_HOLD: begin
        if (!result_valid || !result_stall) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    sample_stall = (state != S_IDLE);
    out_load     = (state == S_HOLD) && (!result_valid || !result_stall);
    rd_en        = 1'b0;
    rd_addr      = AW'(idx_res.idx);
    wr_en        = 1'b0;
    wr_addr      = cur_addr;
    wr_data      = count_inc;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      S_IDLE: begin
        rd_en   = accept && in_mode == MODE_READ && read_ok;
        rd_addr = AW'(read_index);
      end
      S_INDEX: rd_en = idx_res.done && !idx_fault;
      S_UPDATE: wr_en = (cur_mode == MODE_ADD);
      S_HOLD: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      clr_item     <= 1'b0;
      result_valid <= 1'b0;
      var_count    <= VARS_W'(4);
      card_a       <= VALUE_W'(8);
      card_b       <= VALUE_W'(8);
      card_c       <= VALUE_W'(8);
      card_d       <= VALUE_W'(8);
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= sweep_last ? '0 : clr_addr + AW'(1);
      end
      if (accept && in_mode == MODE_CLEAR) begin
        clr_item <= 1'b1;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_VAR_COUNT: var_count <= cfg_data[VARS_W-1:0];
          REG_CARD_A:    card_a    <= cfg_data;
          REG_CARD_B:    card_b    <= cfg_data;
          REG_CARD_C:    card_c    <= cfg_data;
          REG_CARD_D:    card_d    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_mode    <= in_mode;
      stage_index <= (in_mode == MODE_READ) ? read_index : '0;
      stage_count <= '0;
      stage_bad   <= 1'b0;
    end
    if (state == S_INDEX && idx_res.done) begin
      cur_addr    <= AW'(idx_res.idx);
      stage_index <= idx_fault ? '0 : idx_res.idx[INDEX_OUT_W-1:0];
      stage_bad   <= idx_fault;
    end
    if (state == S_UPDATE) begin
      stage_count <= count_wide[COUNT_OUT_W-1:0];
    end
    if (out_load) begin
      cell_index <= stage_index;
      cell_count <= stage_count;
      bad_value  <= stage_bad;
    end
  end

  `MRCH_ASSERT_IMP(a_done_in_index, clk, rst, idx_res.done, state == S_INDEX)
  `MRCH_ASSERT_IMP(a_bad_zero, clk, rst, result_valid && bad_value, cell_index == '0 && cell_count == '0)
  `MRCH_ASSERT_NEXT(a_hold_loads, clk, rst, state == S_HOLD && !result_valid, result_valid)

endmodule

`default_nettype wire

### hdl/mrch_index_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module mrch_index_unit (
  input  wire logic                                               clk,
  input  wire logic                                               rst,
  input  wire logic                                               start,
  input  wire logic [mrch_pkg::VARS_W-1:0]                        vars,
  input  wire logic [mrch_pkg::NUM_FIELDS-1:0][mrch_pkg::VALUE_W-1:0] values,
  input  wire logic [mrch_pkg::NUM_FIELDS-1:0][mrch_pkg::CARD_W-1:0]  cards,
  output mrch_pkg::idx_result_t                                   res
);
  import mrch_pkg::*;

  // Horner evaluation, most significant used digit first, one digit a cycle.
  logic                                  busy;
  logic                                  done;
  logic                                  bad;
  logic [DIG_W-1:0]                      digit;
  logic [IDX_W-1:0]                      acc;
  logic [NUM_FIELDS-1:0][VALUE_W-1:0]    vals;
  logic [NUM_FIELDS-1:0][CARD_W-1:0]     crds;

  logic [VALUE_W-1:0]      cur_val;
  logic [CARD_W-1:0]       cur_card;
  logic                    digit_bad;
  logic [IDX_W+CARD_W-1:0] prod;
  logic [IDX_W-1:0]        acc_next;

  always_comb begin
    cur_val   = vals[digit];
    cur_card  = crds[digit];
    digit_bad = (cur_val == '0) || ({1'b0, cur_val} > cur_card);
    prod      = acc * cur_card;
    acc_next  = IDX_W'(prod + (IDX_W + CARD_W)'(cur_val - VALUE_W'(1)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && digit == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      vals  <= values;
      crds  <= cards;
      digit <= DIG_W'(vars - VARS_W'(1));
      acc   <= '0;
      bad   <= 1'b0;
    end else if (busy) begin
      acc   <= acc_next;
      bad   <= bad | digit_bad;
      digit <= digit - DIG_W'(1);
    end
  end

  assign res.done = done;
  assign res.bad  = bad;
  assign res.idx  = acc;

endmodule

`default_nettype wire

### hdl/mrch_count_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module mrch_count_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int W     = 16
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output      logic [W-1:0]  rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [W-1:0]  wr_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mrch_pkg::*;

  localparam int IDLE_PCT       = 14;
  localparam int DEPTH          = 4096;
  localparam int VARS_LIMIT     = 4;
  localparam int CARD_LIMIT     = 8;
  localparam int MAX_REPORTS    = 40;
  localparam int SAME_CELL_ADDS = 40;
  localparam int PHASE_WORDS    = 95;
  localparam logic [COUNT_OUT_W-1:0] COUNT_TOP = '1;
  // Indexes 5 to 7 have no register behind them; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER [5] =
    '{REG_VAR_COUNT, REG_CARD_A, REG_CARD_B, REG_CARD_C, REG_CARD_D};

  typedef struct {
    logic [INDEX_OUT_W-1:0] index;
    logic [COUNT_OUT_W-1:0] count;
    logic                   bad;
  } cell_word_t;

  logic                   clk;
  logic                   rst;
  logic                   sample_valid;
  logic                   sample_stall;
  logic [1:0]             mode;
  logic [VALUE_W-1:0]     value_a;
  logic [VALUE_W-1:0]     value_b;
  logic [VALUE_W-1:0]     value_c;
  logic [VALUE_W-1:0]     value_d;
  logic [INDEX_OUT_W-1:0] read_index;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [INDEX_OUT_W-1:0] cell_index;
  logic [COUNT_OUT_W-1:0] cell_count;
  logic                   bad_value;
  logic                   cfg_write;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  // Shadow of the count table, advanced at each accepted word, and of the registers.
  logic [COUNT_OUT_W-1:0] tally [DEPTH];
  logic [2:0]             vars_reg;
  logic [3:0]             card_reg [4];
  logic [INDEX_OUT_W-1:0] last_cell;

  cell_word_t  expected_cells [$];
  int          mismatches;
  bit          idle_on;
  int          hold_request;
  int          hold_left;

  mixed_radix_count_histogram_unit dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .mode         (mode),
    .value_a      (value_a),
    .value_b      (value_b),
    .value_c      (value_c),
    .value_d      (value_d),
    .read_index   (read_index),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cell_index   (cell_index),
    .cell_count   (cell_count),
    .bad_value    (bad_value),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("mixed_radix_count_histogram_unit: mismatch");
    $finish;
  end

  function automatic int unsigned eff_vars();
    if (vars_reg == 0) return 1;
    if (vars_reg > VARS_LIMIT) return VARS_LIMIT;
    return vars_reg;
  endfunction

  function automatic int unsigned eff_card(input int j);
    if (card_reg[j] == 0) return 1;
    if (card_reg[j] > CARD_LIMIT) return CARD_LIMIT;
    return card_reg[j];
  endfunction

  // Works out the result word of one accepted word and updates the shadow table.
  function automatic cell_word_t predict_cell(input mode_t m, input logic [3:0] va, vb, vc,
                                              vd, input logic [INDEX_OUT_W-1:0] ri);
    cell_word_t  w;
    logic [3:0]  vals [4];
    int unsigned weight;
    int unsigned idx;
    int unsigned card;
    int          i;
    bit          bad;
    w = '{index: '0, count: '0, bad: 1'b0};
    vals = '{va, vb, vc, vd};
    case (m)
      MODE_ADD: begin
        weight = 1;
        idx = 0;
        bad = 1'b0;
        for (i = 0; i < eff_vars(); i++) begin
          card = eff_card(i);
          if (!bad) begin
            if (vals[i] == 0 || vals[i] > card) begin
              bad = 1'b1;
            end else begin
              idx += (int'(vals[i]) - 1) * weight;
              weight *= card;
            end
          end
        end
        if (idx >= DEPTH) bad = 1'b1;
        if (bad) begin
          w.bad = 1'b1;
        end else begin
          if (tally[idx] != COUNT_TOP) tally[idx] = tally[idx] + 1'b1;
          w.index = idx[INDEX_OUT_W-1:0];
          w.count = tally[idx];
          last_cell = idx[INDEX_OUT_W-1:0];
        end
      end
      MODE_READ: begin
        w.index = ri;
        w.count = tally[ri];
      end
      MODE_CLEAR: begin
        foreach (tally[k]) tally[k] = '0;
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  function automatic void flag_field(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Result side: checks every accepted word and drives stall, including long hold-offs.
  always @(posedge clk) begin : result_side
    cell_word_t want;
    if (rst === 1'b0 && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (expected_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: word with none expected, index %0d count %0d bad %0b",
                   $time, cell_index, cell_count, bad_value);
      end else begin
        want = expected_cells.pop_front();
        flag_field("cell_index", want.index, cell_index);
        flag_field("cell_count", want.count, cell_count);
        flag_field("bad_value", want.bad, bad_value);
      end
    end
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Valid stays high after acceptance so that back-to-back words need no dip.
  task automatic send_word(input mode_t m, input logic [3:0] va, vb, vc, vd,
                           input logic [INDEX_OUT_W-1:0] ri);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    mode <= m;
    value_a <= va;
    value_b <= vb;
    value_c <= vc;
    value_d <= vd;
    read_index <= ri;
    @(posedge clk);
    while (sample_stall !== 1'b0) @(posedge clk);
    expected_cells.push_back(predict_cell(m, va, vb, vc, vd, ri));
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    do @(posedge clk); while (expected_cells.size() != 0);
  endtask

  // Writes all five registers, then one index that has no register.
  task automatic apply_config(input logic [3:0] vars, ca, cb, cc, cd);
    logic [3:0] vals [5];
    int         r;
    vals = '{vars, ca, cb, cc, cd};
    for (r = 0; r < 5; r++) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_ORDER[r];
      cfg_data <= vals[r];
      @(posedge clk);
      case (REG_ORDER[r])
        REG_VAR_COUNT: vars_reg = vals[r][2:0];
        REG_CARD_A:    card_reg[0] = vals[r];
        REG_CARD_B:    card_reg[1] = vals[r];
        REG_CARD_C:    card_reg[2] = vals[r];
        REG_CARD_D:    card_reg[3] = vals[r];
        default: begin
        end
      endcase
    end
    cfg_write <= 1'b1;
    cfg_index <= REG_SPARE_LO + CFG_IDX_W'($urandom_range(2));
    cfg_data <= CFG_W'($urandom);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Runs on the reset settings: four variables of cardinality eight.
  task automatic test_reset_defaults();
    send_word(MODE_ADD, 1, 1, 1, 1, 0);
    send_word(MODE_ADD, 1, 1, 1, 1, 0);
    send_word(MODE_ADD, 8, 8, 8, 8, 0);
    send_word(MODE_ADD, 2, 3, 4, 5, 0);
    send_word(MODE_ADD, 0, 1, 1, 1, 0);
    send_word(MODE_ADD, 1, 1, 1, 9, 0);
    send_word(MODE_ADD, 15, 15, 15, 15, 12'hFFF);
    send_word(MODE_READ, 0, 0, 0, 0, 0);
    send_word(MODE_READ, 15, 15, 15, 15, 12'hFFF);
    send_word(MODE_READ, 5, 10, 5, 10, 12'hAAA);
    send_word(MODE_NONE, 15, 15, 15, 15, 12'hFFF);
    send_word(MODE_CLEAR, 8, 8, 8, 8, 12'h555);
    send_word(MODE_READ, 1, 1, 1, 1, 0);
    send_word(MODE_ADD, 8, 8, 8, 8, 0);
    wait_drained();
  endtask

  // Register values outside their ranges are folded back into them.
  task automatic test_register_limits();
    apply_config(4'd0, 4'd0, 4'd5, 4'd15, 4'd3);
    send_word(MODE_ADD, 1, 0, 15, 9, 0);
    send_word(MODE_ADD, 2, 1, 1, 1, 0);
    wait_drained();
    apply_config(4'hF, 4'd15, 4'd15, 4'd3, 4'd0);
    send_word(MODE_ADD, 8, 8, 3, 1, 0);
    send_word(MODE_ADD, 1, 1, 1, 2, 0);
    send_word(MODE_ADD, 1, 1, 4, 1, 0);
    send_word(MODE_READ, 0, 0, 0, 0, 12'd191);
    wait_drained();
    apply_config(4'hB, 4'd9, 4'd2, 4'd5, 4'd8);
    send_word(MODE_ADD, 8, 2, 5, 0, 0);
    send_word(MODE_ADD, 1, 3, 1, 1, 0);
    wait_drained();
  endtask

  // The result side holds off while words keep coming, so the block must stall its input.
  task automatic test_backpressure();
    int k;
    apply_config(4'd4, 4'd8, 4'd8, 4'd8, 4'd8);
    idle_on = 1'b0;
    hold_request = 400;
    for (k = 0; k < 16; k++)
      send_word(MODE_ADD, 4'($urandom_range(8, 1)), 4'($urandom_range(8, 1)),
                4'($urandom_range(8, 1)), 4'($urandom_range(8, 1)), 12'($urandom));
    wait_drained();
  endtask

  // Back-to-back adds to one cell; each must see the count left by the one before.
  task automatic test_repeat_cell();
    int k;
    apply_config(4'd1, 4'd1, 4'($urandom), 4'($urandom), 4'($urandom));
    idle_on = 1'b0;
    send_word(MODE_CLEAR, 0, 0, 0, 0, 0);
    for (k = 0; k < SAME_CELL_ADDS; k++)
      send_word(MODE_ADD, 1, 4'($urandom), 4'($urandom), 4'($urandom), 12'($urandom));
    send_word(MODE_READ, 0, 0, 0, 0, 0);
    wait_drained();
  endtask

  task automatic test_random();
    int          ph;
    int          k;
    int          j;
    int          pick;
    logic [3:0]  v [4];
    logic [11:0] ri;
    mode_t       m;
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: apply_config(4'd4, 4'd8, 4'd8, 4'd8, 4'd8);
        1: apply_config(4'd4, 4'd2, 4'd2, 4'd2, 4'd2);
        2: apply_config(4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
        3: apply_config(4'hF, 4'hF, 4'hF, 4'hF, 4'hF);
        4: apply_config(4'd3, 4'd1, 4'd3, 4'd2, 4'd1);
        default: apply_config(4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                              4'($urandom));
      endcase
      // One phase runs with neither side idling.
      idle_on = (ph != 5);
      for (k = 0; k < PHASE_WORDS; k++) begin
        pick = $urandom_range(99);
        for (j = 0; j < 4; j++)
          v[j] = (j < eff_vars()) ? 4'($urandom_range(eff_card(j), 1)) : 4'($urandom);
        if (pick < 7) begin
          j = $urandom_range(eff_vars() - 1);
          v[j] = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, eff_card(j) + 1));
        end
        ri = $urandom_range(1) ? last_cell : 12'($urandom);
        if (pick < 74) m = MODE_ADD;
        else if (pick < 95) m = MODE_READ;
        else if (pick < 99) m = MODE_NONE;
        else m = MODE_CLEAR;
        send_word(m, v[0], v[1], v[2], v[3], ri);
      end
      wait_drained();
    end
  endtask

  initial begin
    rst <= 1'b1;
    sample_valid <= 1'b0;
    mode <= MODE_ADD;
    value_a <= '0;
    value_b <= '0;
    value_c <= '0;
    value_d <= '0;
    read_index <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_VAR_COUNT;
    cfg_data <= '0;
    foreach (tally[k]) tally[k] = '0;
    vars_reg = 3'd4;
    foreach (card_reg[k]) card_reg[k] = 4'd8;
    last_cell = '0;
    mismatches = 0;
    idle_on = 1'b1;
    hold_request = 0;
    hold_left = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_register_limits();
    test_backpressure();
    test_repeat_cell();
    test_random();

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_cells.size() == 0) begin
      $display("mixed_radix_count_histogram_unit: match");
    end else begin
      $display("mixed_radix_count_histogram_unit: mismatch");
    end
    $finish;
  end

endmodule
